// ----- rtl/core/dar_pm_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dar_pm_pkg: shared types and constants of the radix page map
// Geometry constants, word types, controller state and the command and
// status groups between controller and datapath.
// ----------------------------------------------------------------------------
package dar_pm_pkg;

  localparam int LEVEL_BITS = 9;
  localparam int POOL_PAGES = 256;
  localparam int PAGE_BITS  = 12;

  localparam int ADDR_W         = 48;
  localparam int PA_W           = 20;
  localparam int NUM_LEVELS     = 4;
  localparam int LEVEL_W        = $clog2(NUM_LEVELS);
  localparam int WORD_IDX_BITS  = PAGE_BITS - 3;
  localparam int WORDS_PER_PAGE = 1 << WORD_IDX_BITS;
  localparam int PAGE_NUM_BITS  = $clog2(POOL_PAGES);
  localparam int CNT_BITS       = $clog2(POOL_PAGES + 1);
  localparam int MEM_DEPTH      = POOL_PAGES * WORDS_PER_PAGE;
  localparam int MEM_ADDR_BITS  = PAGE_NUM_BITS + WORD_IDX_BITS;

  typedef enum logic [1:0] {
    OP_TRANSLATE  = 2'd0,
    OP_TRANSLATE_ALLOC = 2'd1,
    OP_FILL       = 2'd2,
    OP_CHECK      = 2'd3
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [ADDR_W-1:0] address;
    logic [7:0]        value;
    logic              run_end;
  } in_word_t;

  typedef struct packed {
    logic            ok;
    logic [PA_W-1:0] pool_address;
    logic            byte_matches;
    logic            run_ok;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ROOT,
    ST_LVL_RD,
    ST_LVL_CHK,
    ST_DATA_RD,
    ST_DATA_CHK,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic capture;
    logic clear;
    logic root;
    logic lvl_rd;
    logic lvl_chk;
    logic data_rd;
    logic data_chk;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic skip;
    logic root_ok;
    logic step_ok;
    logic level_zero;
    logic data_op;
  } status_t;

  // Table index of one level, wrapped to the word count of a page.
  function automatic logic [WORD_IDX_BITS-1:0] table_index(
    input logic [ADDR_W-1:0]  addr,
    input logic [LEVEL_W-1:0] level
  );
    logic [ADDR_W-1:0]     sh;
    logic [LEVEL_BITS-1:0] idx;
    sh  = addr >> (PAGE_BITS + LEVEL_BITS * int'(level));
    idx = sh[LEVEL_BITS-1:0];
    return WORD_IDX_BITS'(idx);
  endfunction

  // Low bits of the byte offset of an address within the pool.
  function automatic logic [PA_W-1:0] pool_offset(
    input logic [PAGE_NUM_BITS-1:0] page,
    input logic [PAGE_BITS-1:0]     off
  );
    logic [63:0] b;
    b = (64'(page) << PAGE_BITS) | 64'(off);
    return b[PA_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/dar_pm_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dar_pm_ctrl: sequencer of the page map walk
// Steps the datapath through the clearing pass, the root check, the four
// table levels and the data access of one word.
// ----------------------------------------------------------------------------
module dar_pm_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire dar_pm_pkg::status_t status,
  output dar_pm_pkg::cmd_t         cmd,
  output logic                     busy
);
  import dar_pm_pkg::*;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (status.clear_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) state_nxt = ST_ROOT;
      end
      ST_ROOT: begin
        if (status.skip || !status.root_ok) state_nxt = ST_FINISH;
        else state_nxt = ST_LVL_RD;
      end
      ST_LVL_RD: state_nxt = ST_LVL_CHK;
      ST_LVL_CHK: begin
        if (!status.step_ok) state_nxt = ST_FINISH;
        else if (!status.level_zero) state_nxt = ST_LVL_RD;
        else if (status.data_op) state_nxt = ST_DATA_RD;
        else state_nxt = ST_FINISH;
      end
      ST_DATA_RD:  state_nxt = ST_DATA_CHK;
      ST_DATA_CHK: state_nxt = ST_FINISH;
      ST_FINISH:   state_nxt = ST_IDLE;
      default:     state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state_r)
      ST_CLEAR: cmd.clear = 1'b1;
      ST_IDLE: begin
        busy        = 1'b0;
        cmd.capture = start;
      end
      ST_ROOT:     cmd.root     = !status.skip;
      ST_LVL_RD:   cmd.lvl_rd   = 1'b1;
      ST_LVL_CHK:  cmd.lvl_chk  = 1'b1;
      ST_DATA_RD:  cmd.data_rd  = 1'b1;
      ST_DATA_CHK: cmd.data_chk = 1'b1;
      ST_FINISH:   cmd.finish   = 1'b1;
      default:     cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/dar_pm_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dar_pm_dp: datapath of the page map
// Holds the page pool memory, the root pointer, the bump allocator, the run
// accumulator and the result register.
// ----------------------------------------------------------------------------
module dar_pm_dp (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire dar_pm_pkg::in_word_t in_data,
  input  wire dar_pm_pkg::cmd_t     cmd,
  output dar_pm_pkg::status_t       status,
  output logic                      out_valid,
  output dar_pm_pkg::out_word_t     out_data
);
  import dar_pm_pkg::*;

  logic [63:0] mem [MEM_DEPTH];
  logic [63:0] rdata_r;

  in_word_t               item_r;
  logic [CNT_BITS-1:0]    cur_r, cur_nxt;
  logic [LEVEL_W-1:0]     level_r, level_nxt;
  logic                   walk_ok_r, walk_ok_nxt;
  logic                   match_r, match_nxt;
  logic [CNT_BITS-1:0]    root_page_r, root_page_nxt;
  logic [CNT_BITS-1:0]    pages_used_r, pages_used_nxt;
  logic                   run_acc_r, run_acc_nxt;
  logic                   out_valid_r, out_valid_nxt;
  out_word_t              out_r, out_nxt;
  logic [MEM_ADDR_BITS-1:0] clr_cnt_r, clr_cnt_nxt;

  logic                     allocate, can_alloc, ent_valid, root_valid, data_op;
  logic [CNT_BITS-1:0]      new_page;
  logic [PAGE_NUM_BITS-1:0] cur_page;
  logic [MEM_ADDR_BITS-1:0] tbl_addr, data_addr, maddr;
  logic [63:0]              wdata, merged;
  logic                     we, re;
  logic [5:0]               sh;
  logic [7:0]               stored_byte;
  logic                     success, acc_upd;

  always_comb begin
    data_op    = (item_r.op == OP_FILL) || (item_r.op == OP_CHECK);
    allocate   = (item_r.op == OP_TRANSLATE_ALLOC) || (item_r.op == OP_FILL);
    can_alloc  = pages_used_r < CNT_BITS'(POOL_PAGES);
    new_page   = pages_used_r + CNT_BITS'(1);
    root_valid = (root_page_r != '0) && (root_page_r <= CNT_BITS'(POOL_PAGES));
    ent_valid  = (rdata_r != 64'd0) && (rdata_r <= 64'(POOL_PAGES));
    cur_page   = PAGE_NUM_BITS'(cur_r - CNT_BITS'(1));
    tbl_addr   = {cur_page, table_index(item_r.address, level_r)};
    data_addr  = {cur_page, item_r.address[PAGE_BITS-1:3]};
    sh          = {item_r.address[2:0], 3'b000};
    stored_byte = 8'(rdata_r >> sh);
    merged      = (rdata_r & ~(64'hFF << sh)) | (64'(item_r.value) << sh);
  end

  always_comb begin
    status.clear_last = clr_cnt_r == MEM_ADDR_BITS'(MEM_DEPTH - 1);
    status.skip       = data_op && !run_acc_r;
    status.root_ok    = root_valid || (allocate && can_alloc);
    status.step_ok    = ent_valid || (allocate && can_alloc);
    status.level_zero = level_r == '0;
    status.data_op    = data_op;
  end

  // One memory port: the clearing pass, table entries and data words share it.
  always_comb begin
    maddr = tbl_addr;
    wdata = 64'(new_page);
    we    = 1'b0;
    re    = 1'b0;
    if (cmd.clear) begin
      maddr = clr_cnt_r;
      wdata = 64'd0;
      we    = 1'b1;
    end else if (cmd.lvl_rd) begin
      re = 1'b1;
    end else if (cmd.lvl_chk) begin
      we = !ent_valid && allocate && can_alloc;
    end else if (cmd.data_rd) begin
      maddr = data_addr;
      re    = 1'b1;
    end else if (cmd.data_chk) begin
      maddr = data_addr;
      wdata = merged;
      we    = (item_r.op == OP_FILL) && walk_ok_r;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[maddr] <= wdata;
    if (re) rdata_r <= mem[maddr];
  end

  always_comb begin
    cur_nxt        = cur_r;
    level_nxt      = level_r;
    walk_ok_nxt    = walk_ok_r;
    match_nxt      = match_r;
    root_page_nxt  = root_page_r;
    pages_used_nxt = pages_used_r;
    run_acc_nxt    = run_acc_r;
    out_valid_nxt  = 1'b0;
    out_nxt        = out_r;
    clr_cnt_nxt    = clr_cnt_r;
    success        = walk_ok_r && (item_r.op != OP_CHECK || match_r);
    acc_upd        = run_acc_r && success;

    if (cmd.clear) clr_cnt_nxt = clr_cnt_r + MEM_ADDR_BITS'(1);
    if (cmd.capture) begin
      walk_ok_nxt = 1'b0;
      match_nxt   = 1'b0;
    end
    if (cmd.root) begin
      level_nxt = LEVEL_W'(NUM_LEVELS - 1);
      if (root_valid) begin
        cur_nxt = root_page_r;
      end else if (allocate && can_alloc) begin
        pages_used_nxt = new_page;
        root_page_nxt  = new_page;
        cur_nxt        = new_page;
      end
    end
    if (cmd.lvl_chk) begin
      level_nxt = level_r - LEVEL_W'(1);
      if (ent_valid) begin
        cur_nxt = CNT_BITS'(rdata_r);
      end else if (allocate && can_alloc) begin
        pages_used_nxt = new_page;
        cur_nxt        = new_page;
      end
      if (level_r == '0) walk_ok_nxt = status.step_ok;
    end
    if (cmd.data_chk && item_r.op == OP_CHECK) begin
      match_nxt = stored_byte == item_r.value;
    end
    if (cmd.finish) begin
      out_valid_nxt        = 1'b1;
      out_nxt.ok           = walk_ok_r;
      out_nxt.pool_address = walk_ok_r ?
                             pool_offset(cur_page, item_r.address[PAGE_BITS-1:0]) : '0;
      out_nxt.byte_matches = match_r;
      if (data_op) begin
        out_nxt.run_ok = item_r.run_end && acc_upd;
        run_acc_nxt    = item_r.run_end ? 1'b1 : acc_upd;
      end else begin
        out_nxt.run_ok = walk_ok_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) item_r <= in_data;
    cur_r     <= cur_nxt;
    level_r   <= level_nxt;
    walk_ok_r <= walk_ok_nxt;
    match_r   <= match_nxt;
    out_r     <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_page_r  <= '0;
      pages_used_r <= '0;
      run_acc_r    <= 1'b1;
      out_valid_r  <= 1'b0;
      clr_cnt_r    <= '0;
    end else begin
      root_page_r  <= root_page_nxt;
      pages_used_r <= pages_used_nxt;
      run_acc_r    <= run_acc_nxt;
      out_valid_r  <= out_valid_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

// ----- rtl/core/demand_allocated_radix_page_map_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// demand_allocated_radix_page_map_unit: four-level radix page map over a pool
// Top level of a shadow-memory map that allocates table and data pages on
// demand from a bump allocator and fills or checks bytes in them.
// ----------------------------------------------------------------------------
// Usage. A word is handed in on in_data and accepted at a rising edge where
// start is high and busy is low. The block then walks the root pointer and
// four table levels, allocating missing pages for translate-allocating and
// fill words, and for fill and check words reads (and for fill rewrites) the
// data word. Each table level takes a read state and then a state that
// evaluates and possibly writes an entry on the single pool memory port, and
// the data access likewise a read and a check state. The result word appears
// on out_data, marked by out_valid for exactly one cycle. A walk that fails
// early, or a byte skipped after a failure in its run, goes from the root
// check or the failing level straight to the finish state. busy drops in the
// cycle the strobe is shown, so the next word may be accepted in that cycle.
// There is no backpressure: the receiver must take each result as it appears.
// After reset the block sweeps the whole pool to zero, one 64-bit word per
// cycle (131072 words), with busy high; no word is accepted until it ends.
// ----------------------------------------------------------------------------
module demand_allocated_radix_page_map_unit (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire dar_pm_pkg::in_word_t  in_data,
  output logic                       busy,
  output logic                       out_valid,
  output dar_pm_pkg::out_word_t      out_data
);
  import dar_pm_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequencer: one state per step of the walk.
  dar_pm_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  // Pool memory, allocator, run accumulator and result register.
  dar_pm_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
